@@ hw/rtl/index_remap_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// index_remap_table_core_defines
// Assertion macros for the index remap table RTL.
// ----------------------------------------------------------------------------
`ifndef INDEX_REMAP_TABLE_CORE_DEFINES_SVH
`define INDEX_REMAP_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("index remap table: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("index remap table: assertion failed");

// The expression must never be true.
`define IRT_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("index remap table: assertion failed");

`endif

@@ hw/rtl/irt_pkg.sv @@
// ----------------------------------------------------------------------------
// irt_pkg
// Widths, operation codes and the memory request type of the remap table.
// ----------------------------------------------------------------------------
package irt_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int ENTRY_W     = 8;

	// Item field widths.
	localparam int OP_W  = 3;
	localparam int IDX_W = 8;

	// Size register and the width used for size and index compares.
	localparam int CFG_W = 9;
	localparam int CNT_W = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
	localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
	localparam logic [OP_W-1:0] OP_SWAP    = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
	localparam logic [OP_W-1:0] OP_BDELETE = 3'd3;
	localparam logic [OP_W-1:0] OP_BSWAP   = 3'd4;
	localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd5;

	// Request from the sequencer to the table store.
	typedef struct packed {
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
		logic               wr_en;
		logic [ADDR_W-1:0]  wr_addr;
		logic [ENTRY_W-1:0] wr_data;
		logic               init_en;
		logic [CNT_W-1:0]   init_size;
	} mem_req_t;

endpackage

@@ hw/rtl/irt_cmd_if.sv @@
// ----------------------------------------------------------------------------
// irt_cmd_if
// Command channel: one operation item with its index fields.
// ----------------------------------------------------------------------------
interface irt_cmd_if;

	logic                       valid;
	logic                       ready;
	logic [irt_pkg::OP_W-1:0]   operation;
	logic [irt_pkg::IDX_W-1:0]  first_index;
	logic [irt_pkg::IDX_W-1:0]  last_index;
	logic [irt_pkg::IDX_W-1:0]  other_index;

	modport source (
		output valid, operation, first_index, last_index, other_index,
		input  ready
	);

	modport sink (
		input  valid, operation, first_index, last_index, other_index,
		output ready
	);

endinterface

@@ hw/rtl/irt_res_if.sv @@
// ----------------------------------------------------------------------------
// irt_res_if
// Result channel: one value and status item per command.
// ----------------------------------------------------------------------------
interface irt_res_if;

	logic                         valid;
	logic                         ready;
	logic [irt_pkg::ENTRY_W-1:0]  value;
	logic                         status;

	modport source (
		output valid, value, status,
		input  ready
	);

	modport sink (
		input  valid, value, status,
		output ready
	);

endinterface

@@ hw/rtl/irt_ram.sv @@
// ----------------------------------------------------------------------------
// irt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module irt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/irt_store.sv @@
// ----------------------------------------------------------------------------
// irt_store
// Table storage: the entry RAM plus one valid bit per entry. An entry whose
// valid bit is clear reads as its own index, which gives the identity
// contents after reset and after an init without touching the RAM.
// ----------------------------------------------------------------------------
module irt_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  irt_pkg::mem_req_t            req,
	output logic [irt_pkg::ENTRY_W-1:0]  rd_data
);

	logic [irt_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [irt_pkg::ENTRY_W-1:0]     ram_rdata;
	logic                            rvld_s1;
	logic [irt_pkg::ADDR_W-1:0]      raddr_s1;

	irt_ram #(
		.WIDTH (irt_pkg::ENTRY_W),
		.DEPTH (irt_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.wr_addr),
		.wdata (req.wr_data),
		.re    (req.rd_en),
		.raddr (req.rd_addr),
		.rdata (ram_rdata)
	);

	// Valid bits: set on write, cleared below the active size on init.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.init_en) begin
			for (int k = 0; k < irt_pkg::TABLE_DEPTH; k++) begin
				if (irt_pkg::CNT_W'(k) < req.init_size) begin
					valid_q[k] <= 1'b0;
				end
			end
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// Sample the valid bit and address alongside the RAM read.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rvld_s1  <= valid_q[req.rd_addr];
			raddr_s1 <= req.rd_addr;
		end
	end

	// Unwritten entries read as their index modulo the entry range.
	assign rd_data = rvld_s1 ? ram_rdata : irt_pkg::ENTRY_W'(raddr_s1);

endmodule

@@ hw/rtl/irt_ctrl.sv @@
// ----------------------------------------------------------------------------
// irt_ctrl
// Operation sequencer: checks an item's indices, walks the table through
// read, modify and write-back steps, and holds the result register.
// ----------------------------------------------------------------------------
module irt_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	irt_cmd_if.sink                      cmd,
	irt_res_if.source                    res,
	input  logic [irt_pkg::CNT_W-1:0]    size,
	output irt_pkg::mem_req_t            mem_req,
	input  logic [irt_pkg::ENTRY_W-1:0]  rd_data
);

	localparam int ADDR_W  = irt_pkg::ADDR_W;
	localparam int CNT_W   = irt_pkg::CNT_W;
	localparam int ENTRY_W = irt_pkg::ENTRY_W;

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SW_RA  = 4'd1;
	localparam logic [3:0] S_SW_RB  = 4'd2;
	localparam logic [3:0] S_SW_WA  = 4'd3;
	localparam logic [3:0] S_SW_WB  = 4'd4;
	localparam logic [3:0] S_SHIFT  = 4'd5;
	localparam logic [3:0] S_ZERO   = 4'd6;
	localparam logic [3:0] S_INIT   = 4'd7;
	localparam logic [3:0] S_LK_RD  = 4'd8;
	localparam logic [3:0] S_LK_DAT = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0]         state_q;
	logic [ADDR_W-1:0]  i_q;
	logic [ADDR_W-1:0]  j_q;
	logic [ADDR_W-1:0]  last_q;
	logic [ADDR_W-1:0]  first_q;
	logic [ADDR_W-1:0]  other_q;
	logic [CNT_W-1:0]   len_q;
	logic [ENTRY_W-1:0] hold_q;
	logic               pend_s1;
	logic [ADDR_W-1:0]  waddr_s1;
	logic [ENTRY_W-1:0] res_value_q;
	logic               res_status_q;
	logic               out_valid_q;
	logic [ENTRY_W-1:0] out_value_q;
	logic               out_status_q;

	logic [CNT_W-1:0]   f_ext;
	logic [CNT_W-1:0]   l_ext;
	logic [CNT_W-1:0]   o_ext;
	logic [CNT_W-1:0]   bs_last;
	logic [CNT_W-1:0]   del_other;
	logic               bs_empty;
	logic               bs_flag;
	logic               del_flag;
	logic               lk_hit;
	logic               accept;
	logic               shift_more;
	logic [ADDR_W-1:0]  shift_src;
	logic               out_load;

	// Index checks on the incoming item. A plain swap is a one-entry block swap
	// and a plain delete is a one-entry block delete.
	always_comb begin
		f_ext     = CNT_W'(cmd.first_index);
		l_ext     = CNT_W'(cmd.last_index);
		o_ext     = CNT_W'(cmd.other_index);
		bs_last   = (cmd.operation == irt_pkg::OP_SWAP) ? f_ext : l_ext;
		del_other = (cmd.operation == irt_pkg::OP_DELETE) ? f_ext : o_ext;
		bs_empty  = f_ext > bs_last;
		bs_flag   = (bs_last >= size) || ((o_ext + bs_last - f_ext) >= size);
		del_flag  = (f_ext > del_other) || (del_other >= size);
		lk_hit    = f_ext < size;
	end

	assign accept     = cmd.valid && cmd.ready;
	assign shift_more = i_q > other_q;
	assign shift_src  = ADDR_W'(CNT_W'(i_q) - len_q);
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || res.ready);

	// Memory requests for each step.
	always_comb begin
		mem_req           = '0;
		mem_req.init_size = size;
		unique case (state_q)
			S_SW_RA, S_LK_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = i_q;
			end
			S_SW_RB: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = j_q;
			end
			S_SW_WA: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = i_q;
				mem_req.wr_data = rd_data;
			end
			S_SW_WB: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = j_q;
				mem_req.wr_data = hold_q;
			end
			S_SHIFT: begin
				mem_req.rd_en   = shift_more;
				mem_req.rd_addr = shift_src;
				mem_req.wr_en   = pend_s1;
				mem_req.wr_addr = waddr_s1;
				mem_req.wr_data = rd_data;
			end
			S_ZERO: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = i_q;
				mem_req.wr_data = '0;
			end
			S_INIT: begin
				mem_req.init_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pend_s1      <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			last_q       <= '0;
			first_q      <= '0;
			other_q      <= '0;
			len_q        <= '0;
			hold_q       <= '0;
			waddr_s1     <= '0;
			res_value_q  <= '0;
			res_status_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_SHIFT) && shift_more;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_value_q <= '0;
						unique case (cmd.operation)
							irt_pkg::OP_INIT: begin
								res_status_q <= 1'b0;
								state_q      <= S_INIT;
							end
							irt_pkg::OP_SWAP, irt_pkg::OP_BSWAP: begin
								if (bs_empty) begin
									res_status_q <= 1'b0;
									state_q      <= S_DONE;
								end else if (bs_flag) begin
									res_status_q <= 1'b1;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= 1'b0;
									i_q          <= ADDR_W'(f_ext);
									j_q          <= ADDR_W'(o_ext);
									last_q       <= ADDR_W'(bs_last);
									state_q      <= S_SW_RA;
								end
							end
							irt_pkg::OP_DELETE, irt_pkg::OP_BDELETE: begin
								if (del_flag) begin
									res_status_q <= 1'b1;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= 1'b0;
									first_q      <= ADDR_W'(f_ext);
									other_q      <= ADDR_W'(del_other);
									i_q          <= ADDR_W'(size - CNT_W'(1));
									len_q        <= del_other - f_ext + CNT_W'(1);
									state_q      <= S_SHIFT;
								end
							end
							irt_pkg::OP_LOOKUP: begin
								res_status_q <= 1'b0;
								if (lk_hit) begin
									i_q     <= ADDR_W'(f_ext);
									state_q <= S_LK_RD;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								res_status_q <= 1'b0;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_SW_RA: begin
					state_q <= S_SW_RB;
				end
				S_SW_RB: begin
					// First entry of the pair arrives while the second is read.
					hold_q  <= rd_data;
					state_q <= S_SW_WA;
				end
				S_SW_WA: begin
					state_q <= S_SW_WB;
				end
				S_SW_WB: begin
					if (i_q == last_q) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + ADDR_W'(1);
						j_q     <= j_q + ADDR_W'(1);
						state_q <= S_SW_RA;
					end
				end
				S_SHIFT: begin
					// Read the entry len_q below, write it in the next cycle, from the top down.
					waddr_s1 <= i_q;
					if (shift_more) begin
						i_q <= i_q - ADDR_W'(1);
					end else if (!pend_s1) begin
						i_q     <= first_q;
						state_q <= S_ZERO;
					end
				end
				S_ZERO: begin
					if (i_q == other_q) begin
						state_q <= S_DONE;
					end else begin
						i_q <= i_q + ADDR_W'(1);
					end
				end
				S_INIT: begin
					state_q <= S_DONE;
				end
				S_LK_RD: begin
					state_q <= S_LK_DAT;
				end
				S_LK_DAT: begin
					res_value_q <= rd_data;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register decouples the result from the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= 1'b1;
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign cmd.ready  = (state_q == S_IDLE);
	assign res.valid  = out_valid_q;
	assign res.value  = out_value_q;
	assign res.status = out_status_q;

endmodule

@@ hw/rtl/index_remap_table_core.sv @@
// ----------------------------------------------------------------------------
// index_remap_table_core
// Index remapping table with init, swap, block swap, delete, block delete
// and lookup operations over the first active_size entries.
//
//   Channel  Dir  Handshake    Contents
//   cmd      in   valid/ready  operation, first/last/other index
//   res      out  valid/ready  value, status (one item per command)
//   cfg      in   write enable active_size
//
// One item at a time, paced by the single-read-port entry RAM. Flagged edits,
// empty block swaps, out-of-range lookups and unused codes go straight to
// the result without touching the table.
// After reset the table is identity at once through per-entry valid bits.
// The result register frees the sequencer; a stalled result holds the next item.
// ----------------------------------------------------------------------------
`include "index_remap_table_core_defines.svh"

module index_remap_table_core (
	input  logic                        clk,
	input  logic                        arst_n,
	irt_cmd_if.sink                     cmd,
	irt_res_if.source                   res,
	input  logic                        cfg_wr_en,
	input  logic [irt_pkg::CFG_W-1:0]   cfg_wr_data
);

	logic [irt_pkg::CFG_W-1:0]   active_size_q;
	logic [irt_pkg::CNT_W-1:0]   size_ext;
	logic [irt_pkg::CNT_W-1:0]   eff_size;
	irt_pkg::mem_req_t           mem_req;
	logic [irt_pkg::ENTRY_W-1:0] rd_data;

	// Size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= irt_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			active_size_q <= cfg_wr_data;
		end
	end

	// Effective size is capped at the table depth.
	assign size_ext = irt_pkg::CNT_W'(active_size_q);
	assign eff_size = (size_ext < irt_pkg::CNT_W'(irt_pkg::TABLE_DEPTH)) ?
		size_ext : irt_pkg::CNT_W'(irt_pkg::TABLE_DEPTH);

	irt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.res     (res),
		.size    (eff_size),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	irt_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// An accepted item keeps the sequencer busy in the following cycle.
	`IRT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd.valid && cmd.ready, !cmd.ready)

	// A flagged edit never returns a table value.
	`IRT_ASSERT_IMPL(a_flag_zero_value, clk, arst_n, res.valid && res.status, res.value == '0)

	// The sequencer never reads an entry in the cycle it writes that entry.
	`IRT_ASSERT_NEVER(a_no_rw_same_entry, clk, arst_n,
		mem_req.rd_en && mem_req.wr_en && mem_req.rd_addr == mem_req.wr_addr)

endmodule

@@ sim/irt_remap_checker.sv @@
// ----------------------------------------------------------------------------
// irt_remap_checker
// Watches the command, result and size-register ports of the remap table.
// It keeps its own copy of the table and of the size, works out the value
// and status of each accepted command, and compares every accepted result
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irt_remap_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	irt_cmd_if                         cmd,
	irt_res_if                         res,
	input  logic                       cfg_wr_en,
	input  logic [irt_pkg::CFG_W-1:0]  cfg_wr_data,
	output int                         error_count,
	output int                         expect_count
);

	import irt_pkg::*;

	typedef struct packed {
		logic [ENTRY_W-1:0] value;
		logic               status;
	} remap_reply_t;

	// Shadow copy of the table and of the size register.
	logic [ENTRY_W-1:0] table_copy [TABLE_DEPTH];
	logic [CFG_W-1:0]   size_copy;

	// Predicted replies, oldest first.
	remap_reply_t       remap_replies [$];
	remap_reply_t       want;

	function automatic void swap_entries(int a, int b);
		logic [ENTRY_W-1:0] t;
		t = table_copy[a];
		table_copy[a] = table_copy[b];
		table_copy[b] = t;
	endfunction

	// Applies one command to the shadow table and returns its reply.
	function automatic remap_reply_t apply_remap_op(logic [OP_W-1:0] op,
			logic [IDX_W-1:0] first_idx, logic [IDX_W-1:0] last_idx,
			logic [IDX_W-1:0] other_idx);
		remap_reply_t r;
		int n, f, l, o, i, len;
		r = '0;
		n = (int'(size_copy) < TABLE_DEPTH) ? int'(size_copy) : TABLE_DEPTH;
		f = int'(first_idx);
		l = int'(last_idx);
		o = int'(other_idx);
		case (op)
			OP_INIT: begin
				for (i = 0; i < n; i++)
					table_copy[i] = ENTRY_W'(i);
			end
			OP_SWAP: begin
				if (f >= n || o >= n)
					r.status = 1'b1;
				else
					swap_entries(f, o);
			end
			OP_DELETE: begin
				if (f >= n) begin
					r.status = 1'b1;
				end else begin
					for (i = n - 1; i > f; i--)
						table_copy[i] = table_copy[i - 1];
					table_copy[f] = '0;
				end
			end
			OP_BDELETE: begin
				if (f > o || o >= n) begin
					r.status = 1'b1;
				end else begin
					len = o - f + 1;
					for (i = n - 1; i > o; i--)
						table_copy[i] = table_copy[i - len];
					for (i = f; i <= o; i++)
						table_copy[i] = '0;
				end
			end
			OP_BSWAP: begin
				// An empty source block is a no-op that still succeeds.
				if (f <= l) begin
					if (l >= n || o + (l - f) >= n)
						r.status = 1'b1;
					else
						for (i = f; i <= l; i++)
							swap_entries(i, o + (i - f));
				end
			end
			OP_LOOKUP: begin
				if (f < n)
					r.value = table_copy[f];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Predict on every accepted command and check every accepted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				table_copy[i] = ENTRY_W'(i);
			size_copy = CFG_RESET;
			remap_replies.delete();
			error_count = 0;
			expect_count <= 0;
		end else begin
			if (cfg_wr_en)
				size_copy = cfg_wr_data;
			if (cmd.valid && cmd.ready)
				remap_replies.push_back(apply_remap_op(cmd.operation, cmd.first_index,
					cmd.last_index, cmd.other_index));
			if (res.valid && res.ready) begin
				if (remap_replies.size() == 0) begin
					$error("unexpected result: value %0d, status %0d", res.value, res.status);
					error_count++;
				end else begin
					want = remap_replies.pop_front();
					if (res.value !== want.value) begin
						$error("value: expected %0d, got %0d", want.value, res.value);
						error_count++;
					end
					if (res.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res.status);
						error_count++;
					end
				end
			end
			expect_count <= remap_replies.size();
		end
	end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Top-level bench for the index remap table core. A directed pass covers the
// boundary indexes, every operation and the rejected and empty cases at sizes
// 256, 0 and 1; then random phases, each at a new table size, send mostly
// in-range commands with randomized gaps and result back-pressure. Checking
// is done by the checker module instantiated beside the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import irt_pkg::*;

	// Unused operation codes; the core answers them with value 0, status 0.
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam int RANDOM_ITEMS = 2000;
	localparam int HOLD_CYCLES  = 400;
	// Longest command is a full-table shift.
	localparam int SETTLE_CYCLES = 300;
	// Worst case of every item at its longest plus hold-offs,
	// taken several times over.
	localparam int CYCLE_LIMIT = 3_000_000;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CFG_W-1:0]  cfg_wr_data;

	irt_cmd_if cmd_ch ();
	irt_res_if res_ch ();

	int error_count;
	int expect_count;
	int cycle_count = 0;
	int cur_size    = CFG_RESET;
	int random_sent = 0;
	int size_writes = 0;
	int op_count [8];

	bit sender_no_gaps = 1'b0;
	bit sink_no_stalls = 1'b0;
	bit hold_results   = 1'b0;

	index_remap_table_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.res         (res_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	irt_remap_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.res          (res_ch),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.error_count  (error_count),
		.expect_count (expect_count)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Result side: random stalls per item, with one-off long hold-offs on request.
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_results) begin
				hold_results = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = sink_no_stalls ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	// Offers one command after a random gap and returns once it is accepted.
	task automatic send_cmd(logic [OP_W-1:0] op, logic [IDX_W-1:0] first_idx,
			logic [IDX_W-1:0] last_idx, logic [IDX_W-1:0] other_idx);
		int gap;
		gap = sender_no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.operation   <= op;
		cmd_ch.first_index <= first_idx;
		cmd_ch.last_index  <= last_idx;
		cmd_ch.other_index <= other_idx;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		op_count[op]++;
	endtask

	// Drops valid and waits until every predicted result has been returned.
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (expect_count != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_size(int sz);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CFG_W'(sz);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_size = sz;
		size_writes++;
	endtask

	// Mostly an index inside the active size, sometimes anywhere.
	function automatic logic [IDX_W-1:0] pick_index(int n);
		if (n > 0 && $urandom_range(0, 99) < 85)
			return IDX_W'($urandom_range(0, n - 1));
		return IDX_W'($urandom_range(0, 255));
	endfunction

	// One random command, shaped so that most edits land inside the table.
	task automatic send_random_cmd();
		int pick, len, n;
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] f, l, o;
		n    = (cur_size < TABLE_DEPTH) ? cur_size : TABLE_DEPTH;
		pick = $urandom_range(0, 99);
		f    = pick_index(n);
		l    = IDX_W'($urandom);
		o    = pick_index(n);
		if (pick < 30) begin
			op = OP_LOOKUP;
		end else if (pick < 45) begin
			op = OP_SWAP;
		end else if (pick < 55) begin
			op = OP_DELETE;
		end else if (pick < 67) begin
			op = OP_BDELETE;
			if ($urandom_range(0, 9) != 0) begin
				len = $urandom_range(0, 7);
				o = (int'(f) + len > 255) ? IDX_W'(255) : IDX_W'(int'(f) + len);
			end
		end else if (pick < 88) begin
			op = OP_BSWAP;
			len = $urandom_range(0, 7);
			l = (int'(f) + len > 255) ? IDX_W'(255) : IDX_W'(int'(f) + len);
			if (n > len && $urandom_range(0, 9) != 0)
				o = IDX_W'($urandom_range(0, n - 1 - len));
			// Now and then an empty source block.
			if ($urandom_range(0, 9) == 0 && f != 0)
				l = f - 1'b1;
		end else if (pick < 96) begin
			op = OP_INIT;
		end else begin
			op = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
		end
		send_cmd(op, f, l, o);
	endtask

	// Stimulus and verdict.
	initial begin
		int phase_no, phase_len, sel;
		arst_n             <= 1'b0;
		cfg_wr_en          <= 1'b0;
		cfg_wr_data        <= '0;
		cmd_ch.valid       <= 1'b0;
		cmd_ch.operation   <= '0;
		cmd_ch.first_index <= '0;
		cmd_ch.last_index  <= '0;
		cmd_ch.other_index <= '0;
		for (int i = 0; i < 8; i++)
			op_count[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full table straight out of reset.
		send_cmd(OP_LOOKUP, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_LOOKUP, 8'd255, 8'd0, 8'd0);
		send_cmd(OP_SWAP, 8'd0, 8'd0, 8'd255);
		send_cmd(OP_LOOKUP, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_DELETE, 8'd254, 8'd0, 8'd0);
		send_cmd(OP_LOOKUP, 8'd255, 8'd0, 8'd0);
		send_cmd(OP_BDELETE, 8'd10, 8'd0, 8'd12);
		send_cmd(OP_BSWAP, 8'd0, 8'd3, 8'd2);
		send_cmd(OP_BSWAP, 8'd5, 8'd4, 8'd100);
		send_cmd(OP_LOOKUP, 8'd15, 8'd0, 8'd0);
		send_cmd(OP_BDELETE, 8'd0, 8'd0, 8'd255);
		send_cmd(OP_INIT, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_SPARE_6, 8'd255, 8'd255, 8'd255);
		send_cmd(OP_SPARE_7, 8'd255, 8'd255, 8'd255);

		// Empty table: every indexed edit but the empty block swap is rejected, lookups read zero.
		wait_idle();
		write_size(0);
		send_cmd(OP_LOOKUP, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_SWAP, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_DELETE, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_BDELETE, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_BSWAP, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_BSWAP, 8'd1, 8'd0, 8'd0);
		send_cmd(OP_INIT, 8'd0, 8'd0, 8'd0);

		// Single-entry table.
		wait_idle();
		write_size(1);
		send_cmd(OP_SWAP, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_SWAP, 8'd0, 8'd0, 8'd1);
		send_cmd(OP_BDELETE, 8'd1, 8'd0, 8'd0);
		send_cmd(OP_BSWAP, 8'd0, 8'd1, 8'd0);
		send_cmd(OP_DELETE, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_LOOKUP, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_LOOKUP, 8'd1, 8'd0, 8'd0);
		send_cmd(OP_INIT, 8'd0, 8'd0, 8'd0);
		wait_idle();

		// Random phases, each at its own table size and pacing.
		phase_no = 0;
		while (random_sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 19);
			if (sel < 4)
				write_size(256);
			else if (sel == 4)
				write_size(1);
			else if (sel == 5)
				write_size(2);
			else if (sel == 6)
				write_size(0);
			else if (sel < 13)
				write_size($urandom_range(1, 32));
			else
				write_size($urandom_range(1, 256));
			sender_no_gaps = ($urandom_range(0, 3) == 0);
			sink_no_stalls = ($urandom_range(0, 3) == 0);
			// Long result hold-off so the core backs up into its command input.
			if (phase_no == 1 || $urandom_range(0, 9) == 0)
				hold_results = 1'b1;
			phase_len = $urandom_range(40, 120);
			for (int k = 0; k < phase_len; k++) begin
				send_random_cmd();
				random_sent++;
			end
			wait_idle();
			phase_no++;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("tb: %0d random items in %0d phases, %0d size writes", random_sent,
			phase_no, size_writes);
		$display("tb: init %0d, swap %0d, delete %0d, block delete %0d, block swap %0d, lookup %0d, spare %0d",
			op_count[OP_INIT], op_count[OP_SWAP], op_count[OP_DELETE], op_count[OP_BDELETE],
			op_count[OP_BSWAP], op_count[OP_LOOKUP], op_count[OP_SPARE_6] + op_count[OP_SPARE_7]);
		if (error_count == 0 && expect_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
